// ===== rtl/core/llcm_pkg.sv =====
// Shared types and constants for the line-line closest midpoint core.
`default_nettype none

package llcm_pkg;

    // Field and datapath widths
    localparam int W_IN  = 32;                  // point and direction words
    localparam int W_SUM = W_IN + 1;            // point sum and difference
    localparam int W_DOT = 2 * W_IN + 3;        // dot products a..e
    localparam int W_BIG = 2 * W_DOT;           // determinant and numerators
    localparam int W_NUM = W_BIG + W_SUM + 2;   // midpoint numerator
    localparam int W_DEN = W_BIG;               // 2 * determinant
    localparam int QBITS = W_IN;                // quotient bits per coordinate

    // Fixed-point formats and the parallel test
    localparam int DIR_FRAC_BITS = 30;
    localparam int DET_SHIFT     = 4 * DIR_FRAC_BITS - 40;
    localparam logic [31:0] THRESH_RESET = 32'd109951;

    // Saturation bounds
    localparam logic [W_IN-1:0] MID_MAX    = {1'b0, {(W_IN-1){1'b1}}};
    localparam logic [W_IN-1:0] MID_MIN    = {1'b1, {(W_IN-1){1'b0}}};
    localparam logic [W_IN:0]   NEG_LIMIT  = {2'b01, {(W_IN-1){1'b0}}};

    // Multiplier digit size (bits of B consumed per stage)
    localparam int MUL_DIGIT = 8;

    typedef struct packed {
        logic signed [W_IN-1:0] line_a_point_x;
        logic signed [W_IN-1:0] line_a_point_y;
        logic signed [W_IN-1:0] line_a_point_z;
        logic signed [W_IN-1:0] line_a_dir_x;
        logic signed [W_IN-1:0] line_a_dir_y;
        logic signed [W_IN-1:0] line_a_dir_z;
        logic signed [W_IN-1:0] line_b_point_x;
        logic signed [W_IN-1:0] line_b_point_y;
        logic signed [W_IN-1:0] line_b_point_z;
        logic signed [W_IN-1:0] line_b_dir_x;
        logic signed [W_IN-1:0] line_b_dir_y;
        logic signed [W_IN-1:0] line_b_dir_z;
    } llcm_in_t;

    typedef struct packed {
        logic signed [W_IN-1:0] mid_x;
        logic signed [W_IN-1:0] mid_y;
        logic signed [W_IN-1:0] mid_z;
        logic                   lines_parallel;
        logic                   overflowed;
    } llcm_out_t;

    // Geometry carried alongside the dot product multipliers
    typedef struct packed {
        logic [2:0][W_IN-1:0]  pa;
        logic [2:0][W_IN-1:0]  da;
        logic [2:0][W_IN-1:0]  db;
        logic [2:0][W_SUM-1:0] sm;
    } llcm_geo_t;

    // Side data carried alongside the numerator multipliers
    typedef struct packed {
        logic [2:0][W_IN-1:0] pa;
        logic                 par;
        logic [W_BIG-1:0]     det;
    } llcm_m2_t;

endpackage

`default_nettype wire

// ===== rtl/core/llcm_mul.sv =====
// Pipelined signed multiplier lanes, one B digit per stage, with a side tag.
`default_nettype none

module llcm_mul
    import llcm_pkg::*;
#(
    parameter int LANES = 1,
    parameter int AW    = 32,
    parameter int BW    = 32,
    parameter int TW    = 1
) (
    input  logic                   clk,
    input  logic signed [AW-1:0]   a [LANES],
    input  logic signed [BW-1:0]   b [LANES],
    input  logic [TW-1:0]          tag_in,
    output logic signed [AW+BW-1:0] p [LANES],
    output logic [TW-1:0]          tag_out
);

    localparam int NDIG = (BW + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int BPW  = NDIG * MUL_DIGIT;
    localparam int PPW  = AW + MUL_DIGIT + 1;
    localparam int PW   = AW + BPW;

    logic signed [AW-1:0]  a_reg   [NDIG][LANES];
    logic signed [BPW-1:0] b_reg   [NDIG][LANES];
    logic signed [PW-1:0]  acc_reg [NDIG][LANES];
    logic [TW-1:0]         tag_reg [NDIG];

    for (genvar r = 0; r < NDIG; r++) begin : g_stage
        logic signed [AW-1:0]  a_cur    [LANES];
        logic signed [BPW-1:0] b_cur    [LANES];
        logic signed [PW-1:0]  acc_cur  [LANES];
        logic signed [PW-1:0]  acc_next [LANES];
        logic [TW-1:0]         tag_cur;

        if (r == 0) begin : g_first
            always_comb
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    a_cur[l]   = a[l];
                    b_cur[l]   = b[l];
                    acc_cur[l] = '0;
                end
                tag_cur = tag_in;
            end
        end else begin : g_rest
            always_comb
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    a_cur[l]   = a_reg[r-1][l];
                    b_cur[l]   = b_reg[r-1][l];
                    acc_cur[l] = acc_reg[r-1][l];
                end
                tag_cur = tag_reg[r-1];
            end
        end

        // The top digit carries the sign of B; the others are unsigned.
        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                logic signed [MUL_DIGIT:0] dig;
                logic signed [PPW-1:0]     pp;
                logic signed [PW-1:0]      term;
                if (r == NDIG - 1)
                    dig = {b_cur[l][BPW-1], b_cur[l][MUL_DIGIT*r +: MUL_DIGIT]};
                else
                    dig = {1'b0, b_cur[l][MUL_DIGIT*r +: MUL_DIGIT]};
                pp          = a_cur[l] * dig;
                term        = pp;
                term        = term << (MUL_DIGIT * r);
                acc_next[l] = acc_cur[l] + term;
            end
        end

        always_ff @(posedge clk)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                a_reg[r][l]   <= a_cur[l];
                b_reg[r][l]   <= b_cur[l];
                acc_reg[r][l] <= acc_next[l];
            end
            tag_reg[r] <= tag_cur;
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            p[l] = acc_reg[NDIG-1][l][AW+BW-1:0];
        end
    end

    assign tag_out = tag_reg[NDIG-1];

endmodule

`default_nettype wire

// ===== rtl/core/line_line_closest_midpoint_core.sv =====
// Top level: closest-approach midpoint of two 3D lines, fully pipelined.
//
//  channel   | ports                        | handshake
//  ----------+------------------------------+----------------------------------
//  request   | start, busy, request         | item taken when start && !busy
//  result    | done, result                 | one-cycle strobe, no back-pressure
//  config    | cfg_we, cfg_wdata            | parallel_threshold written on cfg_we
//
// The pipeline from start to done: 3 input/product/dot stages,
// 9 stages for the determinant and numerator-of-s/t multipliers (one 8-bit
// digit of a 67-bit operand per stage), 1 subtract stage, 5 stages for the
// midpoint numerator multipliers, 1 sum stage, 1 magnitude stage, 32
// restoring division stages (one quotient bit each) and 1 saturation stage.
// One item enters every cycle; busy never rises. Reset clears the valid
// chain and restores the threshold; datapath registers are not reset.
`default_nettype none

module line_line_closest_midpoint_core
    import llcm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  llcm_in_t  request,
    input  logic      cfg_we,
    input  logic [31:0] cfg_wdata,
    output logic      done,
    output llcm_out_t result
);

    localparam int M1_LAT = (W_DOT + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int M2_LAT = (W_SUM + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int LAT    = 3 + M1_LAT + 1 + M2_LAT + 1 + 1 + QBITS + 1;

    // ------------------------------------------------------------------
    // Control: threshold register and the valid chain
    // ------------------------------------------------------------------
    logic [31:0]    thr_reg;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    assign vld_next = {vld_reg[LAT-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESH_RESET;
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                thr_reg <= cfg_wdata;
            vld_reg <= vld_next;
        end
    end

    assign busy = 1'b0;
    assign done = vld_reg[LAT-1];

    // ------------------------------------------------------------------
    // Stage 0: capture the item, form w = Pa - Pb and Pa + Pb
    // ------------------------------------------------------------------
    logic signed [W_IN-1:0]  pa_in [3];
    logic signed [W_IN-1:0]  da_in [3];
    logic signed [W_IN-1:0]  pb_in [3];
    logic signed [W_IN-1:0]  db_in [3];

    always_comb
    begin
        pa_in[0] = request.line_a_point_x;
        pa_in[1] = request.line_a_point_y;
        pa_in[2] = request.line_a_point_z;
        da_in[0] = request.line_a_dir_x;
        da_in[1] = request.line_a_dir_y;
        da_in[2] = request.line_a_dir_z;
        pb_in[0] = request.line_b_point_x;
        pb_in[1] = request.line_b_point_y;
        pb_in[2] = request.line_b_point_z;
        db_in[0] = request.line_b_dir_x;
        db_in[1] = request.line_b_dir_y;
        db_in[2] = request.line_b_dir_z;
    end

    logic signed [W_IN-1:0]  pa_s0_reg [3];
    logic signed [W_IN-1:0]  da_s0_reg [3];
    logic signed [W_IN-1:0]  db_s0_reg [3];
    logic signed [W_SUM-1:0] w_s0_reg  [3];
    logic signed [W_SUM-1:0] sm_s0_reg [3];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            pa_s0_reg[k] <= pa_in[k];
            da_s0_reg[k] <= da_in[k];
            db_s0_reg[k] <= db_in[k];
            w_s0_reg[k]  <= W_SUM'(pa_in[k]) - W_SUM'(pb_in[k]);
            sm_s0_reg[k] <= W_SUM'(pa_in[k]) + W_SUM'(pb_in[k]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: the fifteen element products of the dot products
    // ------------------------------------------------------------------
    logic signed [2*W_IN-1:0]   aa_reg [3];
    logic signed [2*W_IN-1:0]   ab_reg [3];
    logic signed [2*W_IN-1:0]   bb_reg [3];
    logic signed [2*W_IN:0]     dw_reg [3];
    logic signed [2*W_IN:0]     ew_reg [3];
    llcm_geo_t                  geo_s1_reg;
    llcm_geo_t                  geo_s1_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            geo_s1_next.pa[k] = pa_s0_reg[k];
            geo_s1_next.da[k] = da_s0_reg[k];
            geo_s1_next.db[k] = db_s0_reg[k];
            geo_s1_next.sm[k] = sm_s0_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            aa_reg[k] <= da_s0_reg[k] * da_s0_reg[k];
            ab_reg[k] <= da_s0_reg[k] * db_s0_reg[k];
            bb_reg[k] <= db_s0_reg[k] * db_s0_reg[k];
            dw_reg[k] <= da_s0_reg[k] * w_s0_reg[k];
            ew_reg[k] <= db_s0_reg[k] * w_s0_reg[k];
        end
        geo_s1_reg <= geo_s1_next;
    end

    // ------------------------------------------------------------------
    // Stage 2: sum into a, b, c, d, e
    // ------------------------------------------------------------------
    logic signed [W_DOT-1:0] dot_a_reg, dot_b_reg, dot_c_reg, dot_d_reg, dot_e_reg;
    llcm_geo_t               geo_s2_reg;

    always_ff @(posedge clk)
    begin
        dot_a_reg  <= W_DOT'(aa_reg[0]) + W_DOT'(aa_reg[1]) + W_DOT'(aa_reg[2]);
        dot_b_reg  <= W_DOT'(ab_reg[0]) + W_DOT'(ab_reg[1]) + W_DOT'(ab_reg[2]);
        dot_c_reg  <= W_DOT'(bb_reg[0]) + W_DOT'(bb_reg[1]) + W_DOT'(bb_reg[2]);
        dot_d_reg  <= W_DOT'(dw_reg[0]) + W_DOT'(dw_reg[1]) + W_DOT'(dw_reg[2]);
        dot_e_reg  <= W_DOT'(ew_reg[0]) + W_DOT'(ew_reg[1]) + W_DOT'(ew_reg[2]);
        geo_s2_reg <= geo_s1_reg;
    end

    // ------------------------------------------------------------------
    // Multiplier bank 1: ac, bb, be, cd, ae, bd
    // ------------------------------------------------------------------
    logic signed [W_DOT-1:0] m1_a [6];
    logic signed [W_DOT-1:0] m1_b [6];
    logic signed [W_BIG-1:0] m1_p [6];
    llcm_geo_t               m1_tag;

    always_comb
    begin
        m1_a[0] = dot_a_reg;  m1_b[0] = dot_c_reg;
        m1_a[1] = dot_b_reg;  m1_b[1] = dot_b_reg;
        m1_a[2] = dot_b_reg;  m1_b[2] = dot_e_reg;
        m1_a[3] = dot_c_reg;  m1_b[3] = dot_d_reg;
        m1_a[4] = dot_a_reg;  m1_b[4] = dot_e_reg;
        m1_a[5] = dot_b_reg;  m1_b[5] = dot_d_reg;
    end

    llcm_mul #(
        .LANES (6),
        .AW    (W_DOT),
        .BW    (W_DOT),
        .TW    ($bits(llcm_geo_t))
    ) u_mul_det (
        .clk     (clk),
        .a       (m1_a),
        .b       (m1_b),
        .tag_in  (geo_s2_reg),
        .p       (m1_p),
        .tag_out (m1_tag)
    );

    // ------------------------------------------------------------------
    // Stage 3: D = ac - b^2, s and t numerators
    // ------------------------------------------------------------------
    logic signed [W_BIG-1:0] det_reg, ns_reg, nt_reg;
    llcm_geo_t               geo_s3_reg;

    always_ff @(posedge clk)
    begin
        det_reg    <= m1_p[0] - m1_p[1];
        ns_reg     <= m1_p[2] - m1_p[3];
        nt_reg     <= m1_p[4] - m1_p[5];
        geo_s3_reg <= m1_tag;
    end

    // Parallel test: non-positive D, or D truncated to 2^-40 under threshold.
    logic det_pos;
    logic det_hi_zero;
    logic par_s3;

    assign det_pos     = !det_reg[W_BIG-1] && (|det_reg);
    assign det_hi_zero = ~|det_reg[W_BIG-1:DET_SHIFT+32];
    assign par_s3      = !det_pos || (det_hi_zero && (det_reg[DET_SHIFT +: 32] < thr_reg));

    // ------------------------------------------------------------------
    // Multiplier bank 2: (Pa+Pb)*D, A*ns, B*nt per coordinate
    // ------------------------------------------------------------------
    logic signed [W_BIG-1:0]       m2_a [9];
    logic signed [W_SUM-1:0]       m2_b [9];
    logic signed [W_BIG+W_SUM-1:0] m2_p [9];
    llcm_m2_t                      m2_tag_in;
    llcm_m2_t                      m2_tag;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            m2_a[3*k]     = det_reg;
            m2_b[3*k]     = $signed(geo_s3_reg.sm[k]);
            m2_a[3*k + 1] = ns_reg;
            m2_b[3*k + 1] = W_SUM'($signed(geo_s3_reg.da[k]));
            m2_a[3*k + 2] = nt_reg;
            m2_b[3*k + 2] = W_SUM'($signed(geo_s3_reg.db[k]));
            m2_tag_in.pa[k] = geo_s3_reg.pa[k];
        end
        m2_tag_in.par = par_s3;
        m2_tag_in.det = det_reg;
    end

    llcm_mul #(
        .LANES (9),
        .AW    (W_BIG),
        .BW    (W_SUM),
        .TW    ($bits(llcm_m2_t))
    ) u_mul_num (
        .clk     (clk),
        .a       (m2_a),
        .b       (m2_b),
        .tag_in  (m2_tag_in),
        .p       (m2_p),
        .tag_out (m2_tag)
    );

    // ------------------------------------------------------------------
    // Stage 4: midpoint numerators; stage 5: magnitude and 2D
    // ------------------------------------------------------------------
    logic signed [W_NUM-1:0] num_reg [3];
    llcm_m2_t                m2_s4_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            num_reg[k] <= W_NUM'(m2_p[3*k]) + W_NUM'(m2_p[3*k + 1])
                        + W_NUM'(m2_p[3*k + 2]);
        end
        m2_s4_reg <= m2_tag;
    end

    logic [W_NUM-1:0]     mag_s5_reg [3];
    logic [2:0]           neg_s5_reg;
    logic [W_DEN-1:0]     den_s5_reg;
    logic [2:0][W_IN-1:0] pa_s5_reg;
    logic                 par_s5_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            mag_s5_reg[k] <= num_reg[k][W_NUM-1] ? W_NUM'(-num_reg[k]) : W_NUM'(num_reg[k]);
            neg_s5_reg[k] <= num_reg[k][W_NUM-1];
        end
        den_s5_reg <= {m2_s4_reg.det[W_DEN-2:0], 1'b0};
        pa_s5_reg  <= m2_s4_reg.pa;
        par_s5_reg <= m2_s4_reg.par;
    end

    // ------------------------------------------------------------------
    // Division: one quotient bit per stage, MSB first. The first stage
    // also flags magnitudes at or beyond 2^32 * 2D as overflow.
    // ------------------------------------------------------------------
    logic [W_NUM-1:0]     rem_reg [QBITS][3];
    logic [QBITS-1:0]     q_reg   [QBITS][3];
    logic [2:0]           ovf_reg [QBITS];
    logic [2:0]           neg_reg [QBITS];
    logic [W_DEN-1:0]     den_reg [QBITS];
    logic [2:0][W_IN-1:0] pa_reg  [QBITS];
    logic                 par_reg [QBITS];

    for (genvar j = 0; j < QBITS; j++) begin : g_div
        localparam int BIT = QBITS - 1 - j;

        logic [W_NUM-1:0]     rem_cur  [3];
        logic [QBITS-1:0]     q_cur    [3];
        logic [2:0]           ovf_cur;
        logic [2:0]           neg_cur;
        logic [W_DEN-1:0]     den_cur;
        logic [2:0][W_IN-1:0] pa_cur;
        logic                 par_cur;
        logic [W_NUM-1:0]     rem_next [3];
        logic [QBITS-1:0]     q_next   [3];
        logic [W_NUM-1:0]     dsh;

        if (j == 0) begin : g_first
            always_comb
            begin
                for (int k = 0; k < 3; k++)
                begin
                    rem_cur[k] = mag_s5_reg[k];
                    q_cur[k]   = '0;
                    ovf_cur[k] = mag_s5_reg[k] >= (W_NUM'(den_s5_reg) << QBITS);
                end
                neg_cur = neg_s5_reg;
                den_cur = den_s5_reg;
                pa_cur  = pa_s5_reg;
                par_cur = par_s5_reg;
            end
        end else begin : g_rest
            always_comb
            begin
                for (int k = 0; k < 3; k++)
                begin
                    rem_cur[k] = rem_reg[j-1][k];
                    q_cur[k]   = q_reg[j-1][k];
                end
                ovf_cur = ovf_reg[j-1];
                neg_cur = neg_reg[j-1];
                den_cur = den_reg[j-1];
                pa_cur  = pa_reg[j-1];
                par_cur = par_reg[j-1];
            end
        end

        assign dsh = W_NUM'(den_cur) << BIT;

        always_comb
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (rem_cur[k] >= dsh)
                begin
                    rem_next[k] = rem_cur[k] - dsh;
                    q_next[k]   = q_cur[k] | (QBITS'(1) << BIT);
                end
                else
                begin
                    rem_next[k] = rem_cur[k];
                    q_next[k]   = q_cur[k];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            for (int k = 0; k < 3; k++)
            begin
                rem_reg[j][k] <= rem_next[k];
                q_reg[j][k]   <= q_next[k];
            end
            ovf_reg[j] <= ovf_cur;
            neg_reg[j] <= neg_cur;
            den_reg[j] <= den_cur;
            pa_reg[j]  <= pa_cur;
            par_reg[j] <= par_cur;
        end
    end

    // ------------------------------------------------------------------
    // Final stage: floor for negatives, saturate, pick the parallel case
    // ------------------------------------------------------------------
    llcm_out_t        out_reg;
    llcm_out_t        out_next;
    logic [W_IN-1:0]  mid [3];
    logic [2:0]       sat;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic [QBITS-1:0] q;
            logic [QBITS:0]   qq;
            q  = q_reg[QBITS-1][k];
            qq = {1'b0, q} + (QBITS+1)'(|rem_reg[QBITS-1][k]);
            if (ovf_reg[QBITS-1][k])
            begin
                mid[k] = neg_reg[QBITS-1][k] ? MID_MIN : MID_MAX;
                sat[k] = 1'b1;
            end
            else if (!neg_reg[QBITS-1][k])
            begin
                mid[k] = q[QBITS-1] ? MID_MAX : q;
                sat[k] = q[QBITS-1];
            end
            else if (qq > NEG_LIMIT)
            begin
                mid[k] = MID_MIN;
                sat[k] = 1'b1;
            end
            else
            begin
                mid[k] = W_IN'(-qq);
                sat[k] = 1'b0;
            end
        end

        if (par_reg[QBITS-1])
        begin
            out_next.mid_x          = $signed(pa_reg[QBITS-1][0]);
            out_next.mid_y          = $signed(pa_reg[QBITS-1][1]);
            out_next.mid_z          = $signed(pa_reg[QBITS-1][2]);
            out_next.lines_parallel = 1'b1;
            out_next.overflowed     = 1'b0;
        end
        else
        begin
            out_next.mid_x          = $signed(mid[0]);
            out_next.mid_y          = $signed(mid[1]);
            out_next.mid_z          = $signed(mid[2]);
            out_next.lines_parallel = 1'b0;
            out_next.overflowed     = |sat;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result = out_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_lat_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("item accepted but no result after the pipeline latency");

    a_lat_miss: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##LAT !done)
        else $error("result strobe without a matching item");

    a_par_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.lines_parallel) |-> !result.overflowed)
        else $error("parallel result flagged as overflowed");

    a_ovf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.overflowed) |->
            (result.mid_x == MID_MAX || result.mid_x == MID_MIN ||
             result.mid_y == MID_MAX || result.mid_y == MID_MIN ||
             result.mid_z == MID_MAX || result.mid_z == MID_MIN))
        else $error("overflow flagged but no coordinate at a bound");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for the line-line closest midpoint core: exact-arithmetic prediction and checking.
`timescale 1ns / 1ps

module tb;
    import llcm_pkg::*;

    // Wide enough for every exact intermediate: dot products are 67 bits,
    // the determinant 134 bits and the midpoint numerator about 170 bits.
    typedef logic signed [255:0] wide_t;

    localparam int DRAIN_CYCLES = 60;    // a little past the pipeline latency
    localparam int HANG_LIMIT   = 5000;  // cycles with nothing accepted or done
    localparam int RAND_ITEMS   = 1530;
    localparam int QUIET_TAIL   = 200;   // last items go with no idling

    // Item shapes for the random part
    typedef enum int {SHAPE_NOISE, SHAPE_SKEW, SHAPE_NEAR_PAR, SHAPE_TINY} shape_e;

    // Predicts each midpoint and holds the results still to come.
    class midpoint_board;
        llcm_out_t  pending_mids[$];
        logic [31:0] thresh;
        int          errors;
        int          checked;
        int          n_par;
        int          n_ovf;

        function new();
            thresh  = THRESH_RESET;
            errors  = 0;
            checked = 0;
            n_par   = 0;
            n_ovf   = 0;
        endfunction

        function llcm_out_t solve_midpoint(llcm_in_t r);
            wide_t pa[3], pb[3], da[3], db[3], wv[3];
            wide_t a, b, c, d, e, det, ns, nt, den, num, q, tr, hi, lo;
            llcm_out_t o;
            logic par;
            logic ovf;
            pa[0] = r.line_a_point_x; pa[1] = r.line_a_point_y; pa[2] = r.line_a_point_z;
            da[0] = r.line_a_dir_x;   da[1] = r.line_a_dir_y;   da[2] = r.line_a_dir_z;
            pb[0] = r.line_b_point_x; pb[1] = r.line_b_point_y; pb[2] = r.line_b_point_z;
            db[0] = r.line_b_dir_x;   db[1] = r.line_b_dir_y;   db[2] = r.line_b_dir_z;
            for (int k = 0; k < 3; k++)
                wv[k] = pa[k] - pb[k];
            a = da[0]*da[0] + da[1]*da[1] + da[2]*da[2];
            b = da[0]*db[0] + da[1]*db[1] + da[2]*db[2];
            c = db[0]*db[0] + db[1]*db[1] + db[2]*db[2];
            d = da[0]*wv[0] + da[1]*wv[1] + da[2]*wv[2];
            e = db[0]*wv[0] + db[1]*wv[1] + db[2]*wv[2];
            det = a*c - b*b;
            // A zero determinant is parallel even with a zero threshold.
            if (det <= 0)
                par = 1'b1;
            else
            begin
                tr  = det >>> DET_SHIFT;
                par = ((tr >>> 32) == 0) && (tr[31:0] < thresh);
            end
            o = '0;
            if (par)
            begin
                o.mid_x = r.line_a_point_x;
                o.mid_y = r.line_a_point_y;
                o.mid_z = r.line_a_point_z;
                o.lines_parallel = 1'b1;
                return o;
            end
            ns  = b*e - c*d;
            nt  = a*e - b*d;
            den = det + det;
            hi  = (wide_t'(1) <<< 31) - 1;
            lo  = -hi - 1;
            ovf = 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                num = (pa[k] + pb[k])*det + da[k]*ns + db[k]*nt;
                q   = num / den;
                // Division truncates; step down for negative inexact quotients.
                if (num < 0 && (num % den) != 0)
                    q = q - 1;
                if (q > hi) begin q = hi; ovf = 1'b1; end
                if (q < lo) begin q = lo; ovf = 1'b1; end
                case (k)
                    0: o.mid_x = q[31:0];
                    1: o.mid_y = q[31:0];
                    default: o.mid_z = q[31:0];
                endcase
            end
            o.overflowed = ovf;
            return o;
        endfunction

        function void note_item(llcm_in_t r);
            pending_mids = {pending_mids, solve_midpoint(r)};
        endfunction

        function void check_result(llcm_out_t got);
            llcm_out_t want;
            if (pending_mids.size() == 0)
            begin
                $display("%0t: result with nothing pending: %h", $time, got);
                errors++;
                return;
            end
            want = pending_mids.pop_front();
            checked++;
            if (want.lines_parallel) n_par++;
            if (want.overflowed) n_ovf++;
            if (got.mid_x !== want.mid_x)
            begin
                $display("%0t: mid_x expected %h actual %h", $time, want.mid_x, got.mid_x);
                errors++;
            end
            if (got.mid_y !== want.mid_y)
            begin
                $display("%0t: mid_y expected %h actual %h", $time, want.mid_y, got.mid_y);
                errors++;
            end
            if (got.mid_z !== want.mid_z)
            begin
                $display("%0t: mid_z expected %h actual %h", $time, want.mid_z, got.mid_z);
                errors++;
            end
            if (got.lines_parallel !== want.lines_parallel)
            begin
                $display("%0t: lines_parallel expected %b actual %b", $time,
                         want.lines_parallel, got.lines_parallel);
                errors++;
            end
            if (got.overflowed !== want.overflowed)
            begin
                $display("%0t: overflowed expected %b actual %b", $time,
                         want.overflowed, got.overflowed);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    llcm_in_t    request;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        done;
    llcm_out_t   result;

    midpoint_board board;
    int          stall_cnt;

    line_line_closest_midpoint_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .result    (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Note accepted items and check results on the values of the cycle
    // that the edge ends; the driver's updates land after these reads.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                board.note_item(request);
            if (done)
                board.check_result(result);
            if ((start && !busy) || done)
                stall_cnt <= 0;
            else
                stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= HANG_LIMIT)
            begin
                $display("watchdog: nothing accepted for %0d cycles", HANG_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Present one item after an optional gap; hold it until taken.
    task automatic send_item(llcm_in_t item, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= item;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Let the pipe drain fully, then write the threshold.
    task automatic write_thresh(logic [31:0] value);
        start <= 1'b0;
        @(posedge clk);
        while (board.pending_mids.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        board.thresh = value;
        cfg_we <= 1'b0;
    endtask

    function automatic llcm_in_t make_item(logic [31:0] pax, logic [31:0] pay,
            logic [31:0] paz, logic [31:0] dax, logic [31:0] day, logic [31:0] daz,
            logic [31:0] pbx, logic [31:0] pby, logic [31:0] pbz, logic [31:0] dbx,
            logic [31:0] dby, logic [31:0] dbz);
        llcm_in_t r;
        r = {pax, pay, paz, dax, day, daz, pbx, pby, pbz, dbx, dby, dbz};
        return r;
    endfunction

    function automatic logic [31:0] rand_span(int bits);
        logic [31:0] v;
        v = $urandom;
        if (bits < 32)
            v = $signed(v << (32 - bits)) >>> (32 - bits);
        return v;
    endfunction

    function automatic llcm_in_t random_item();
        llcm_in_t r;
        shape_e shape;
        int pbits;
        int pick;
        pick = $urandom_range(0, 9);
        shape = (pick < 2) ? SHAPE_NOISE : (pick < 6) ? SHAPE_SKEW :
                (pick < 8) ? SHAPE_NEAR_PAR : SHAPE_TINY;
        pbits = $urandom_range(8, 32);
        r.line_a_point_x = rand_span(pbits);
        r.line_a_point_y = rand_span(pbits);
        r.line_a_point_z = rand_span(pbits);
        r.line_b_point_x = rand_span(pbits);
        r.line_b_point_y = rand_span(pbits);
        r.line_b_point_z = rand_span(pbits);
        case (shape)
            SHAPE_NOISE:
            begin
                r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            end
            SHAPE_SKEW:
            begin
                // Directions of roughly unit length, Q2.30
                r.line_a_dir_x = rand_span(31);
                r.line_a_dir_y = rand_span(31);
                r.line_a_dir_z = rand_span(31);
                r.line_b_dir_x = rand_span(31);
                r.line_b_dir_y = rand_span(31);
                r.line_b_dir_z = rand_span(31);
            end
            SHAPE_NEAR_PAR:
            begin
                // Second direction is the first plus a small nudge
                r.line_a_dir_x = rand_span(31);
                r.line_a_dir_y = rand_span(31);
                r.line_a_dir_z = rand_span(31);
                pbits = $urandom_range(1, 24);
                r.line_b_dir_x = r.line_a_dir_x + rand_span(pbits);
                r.line_b_dir_y = r.line_a_dir_y + rand_span(pbits);
                r.line_b_dir_z = r.line_a_dir_z + rand_span(pbits);
            end
            default:
            begin
                r.line_a_dir_x = rand_span(12);
                r.line_a_dir_y = rand_span(12);
                r.line_a_dir_z = rand_span(12);
                r.line_b_dir_x = rand_span(12);
                r.line_b_dir_y = rand_span(12);
                r.line_b_dir_z = rand_span(12);
            end
        endcase
        return r;
    endfunction

    task automatic run_directed();
        localparam logic [31:0] ONE = 32'h4000_0000;   // 1.0 in Q2.30
        localparam logic [31:0] MAXV = 32'h7fff_ffff;
        localparam logic [31:0] MINV = 32'h8000_0000;
        // Zero directions: determinant zero, parallel
        send_item(make_item(1, 2, 3, 0, 0, 0, 4, 5, 6, 0, 0, 0), 0);
        // X axis against Y axis, offset in z: crossing skew lines
        send_item(make_item(0, 0, 32'h10000, ONE, 0, 0, 0, 0, 32'hffff0000,
                            0, ONE, 0), 0);
        // Identical directions: exactly parallel
        send_item(make_item(MAXV, MINV, 7, ONE, ONE, 0, 0, 0, 0, ONE, ONE, 0), 0);
        // Extreme points on perpendicular lines
        send_item(make_item(MAXV, MAXV, MAXV, ONE, 0, 0, MAXV, MAXV, MAXV,
                            0, 0, ONE), 0);
        send_item(make_item(MINV, MINV, MINV, 0, ONE, 0, MINV, MINV, MINV,
                            0, 0, ONE), 0);
        // Extreme directions and points, likely saturating
        send_item(make_item(MAXV, MINV, MAXV, MAXV, MINV, MAXV, MINV, MAXV, MINV,
                            MINV, MAXV, 1), 0);
        send_item(make_item(MINV, MAXV, MINV, MINV, MINV, MINV, MAXV, MINV, MAXV,
                            MAXV, 0, MINV), 0);
        // Tiny crossing angle: determinant below the reset threshold
        send_item(make_item(0, 0, 0, ONE, 0, 0, 32'h100, 0, 0, ONE, 32'h20, 0), 0);
        send_item(make_item(0, 0, 0, ONE, 0, 0, 32'h100, 0, 0, ONE, 32'h800, 0), 0);
        send_item(make_item(0, 0, 0, ONE, 0, 0, 32'h100, 0, 0, ONE, 32'h4000, 0), 0);
        // Small directions push s and t far out
        send_item(make_item(5, 6, 7, 1, 0, 0, 32'h7000_0000, 9, 32'h8000_1000,
                            0, 1, 1), 0);
        // All ones in every field
        send_item(make_item('1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1), 0);
    endtask

    initial
    begin
        llcm_in_t item;
        int gap;
        board     = new();
        stall_cnt = 0;
        rst_n     = 1'b0;
        start     = 1'b0;
        request   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset threshold first, then the extremes and a few random values
        run_directed();
        write_thresh(32'd0);
        run_directed();
        write_thresh(32'hffff_ffff);
        run_directed();

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            // Change the threshold now and then; the write drains the pipe
            if (i % 300 == 150)
            begin
                case ($urandom_range(0, 3))
                    0: write_thresh(32'd0);
                    1: write_thresh(32'hffff_ffff);
                    2: write_thresh(THRESH_RESET);
                    default: write_thresh($urandom);
                endcase
            end
            item = random_item();
            gap = 0;
            if (i < RAND_ITEMS - QUIET_TAIL && ($urandom_range(0, 3) == 0) &&
                ((i / 100) % 3 != 2))
                gap = $urandom_range(1, 11);
            send_item(item, gap);
        end
        start <= 1'b0;

        while (board.pending_mids.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d midpoints: %0d parallel, %0d saturated",
                 board.checked, board.n_par, board.n_ovf);
        $display("threshold swept through zero, reset value, all ones and random");
        if (board.errors == 0 && board.pending_mids.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/llcm_pkg.sv
rtl/core/llcm_mul.sv
rtl/core/line_line_closest_midpoint_core.sv
tb/tb.sv
